// ===== hw/rtl/battery_voltage_filter_assert.svh =====
// Assertion helpers shared by the filter RTL.
`ifndef BATTERY_VOLTAGE_FILTER_ASSERT_SVH
`define BATTERY_VOLTAGE_FILTER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define BVF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define BVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/bvf_pkg.sv =====
package bvf_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int MV_W       = 14;
    localparam int PCT_W      = 7;
    localparam int GAIN_W     = 16;
    localparam int OFFSET_W   = 10;
    localparam int RATIO_W    = 16;
    localparam int AVG_W      = 22;
    localparam int AVG_FRAC   = 8;
    localparam int GAIN_FRAC  = 16;
    localparam int RATIO_FRAC = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int PC_W       = 4;
    localparam int CNT_W      = 3;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SORT_A,
        OP_SORT_B,
        OP_MID,
        OP_MUL_GAIN,
        OP_OFFSET,
        OP_MUL_RATIO,
        OP_SAT,
        OP_EMA,
        OP_PCT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_IN,
        COND_OUT_BUSY,
        COND_BOUND,
        COND_CNT_NZ
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic bound;
        logic cnt_nz;
    } t_status;

    typedef struct packed {
        logic [GAIN_W-1:0]   cal_gain;
        logic [OFFSET_W-1:0] cal_offset;
        logic [RATIO_W-1:0]  divider_ratio;
        logic [MV_W-1:0]     reseed_floor;
        logic [MV_W-1:0]     empty_mv;
        logic [MV_W-1:0]     full_mv;
    } t_cfg;

    localparam t_pc STEP_LOAD      = 4'd0;
    localparam t_pc STEP_SORT_A    = 4'd1;
    localparam t_pc STEP_SORT_B    = 4'd2;
    localparam t_pc STEP_MID       = 4'd3;
    localparam t_pc STEP_MUL_GAIN  = 4'd4;
    localparam t_pc STEP_OFFSET    = 4'd5;
    localparam t_pc STEP_MUL_RATIO = 4'd6;
    localparam t_pc STEP_SAT       = 4'd7;
    localparam t_pc STEP_EMA       = 4'd8;
    localparam t_pc STEP_PCT       = 4'd9;
    localparam t_pc STEP_DIV_INIT  = 4'd10;
    localparam t_pc STEP_DIV       = 4'd11;
    localparam t_pc STEP_WAIT      = 4'd12;
    localparam t_pc STEP_OUT       = 4'd13;

    // Microprogram: a taken condition jumps to target, otherwise fall through.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_LOAD};
        unique case (pc)
            STEP_LOAD:      w = '{op: OP_LOAD,      cond: COND_NO_IN,    target: STEP_LOAD};
            STEP_SORT_A:    w = '{op: OP_SORT_A,    cond: COND_NEXT,     target: STEP_LOAD};
            STEP_SORT_B:    w = '{op: OP_SORT_B,    cond: COND_NEXT,     target: STEP_LOAD};
            STEP_MID:       w = '{op: OP_MID,       cond: COND_NEXT,     target: STEP_LOAD};
            STEP_MUL_GAIN:  w = '{op: OP_MUL_GAIN,  cond: COND_NEXT,     target: STEP_LOAD};
            STEP_OFFSET:    w = '{op: OP_OFFSET,    cond: COND_NEXT,     target: STEP_LOAD};
            STEP_MUL_RATIO: w = '{op: OP_MUL_RATIO, cond: COND_NEXT,     target: STEP_LOAD};
            STEP_SAT:       w = '{op: OP_SAT,       cond: COND_NEXT,     target: STEP_LOAD};
            STEP_EMA:       w = '{op: OP_EMA,       cond: COND_NEXT,     target: STEP_LOAD};
            STEP_PCT:       w = '{op: OP_PCT,       cond: COND_BOUND,    target: STEP_WAIT};
            STEP_DIV_INIT:  w = '{op: OP_DIV_INIT,  cond: COND_NEXT,     target: STEP_LOAD};
            STEP_DIV:       w = '{op: OP_DIV_STEP,  cond: COND_CNT_NZ,   target: STEP_DIV};
            STEP_WAIT:      w = '{op: OP_NOP,       cond: COND_OUT_BUSY, target: STEP_WAIT};
            STEP_OUT:       w = '{op: OP_OUT,       cond: COND_ALWAYS,   target: STEP_LOAD};
            default:        w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/battery_voltage_filter.sv =====
// Battery voltage filter: takes four raw ADC samples per transfer, drops the
// lowest and highest, calibrates and scales the mean of the middle two to
// battery millivolts (saturated at 16383), smooths it with a 3/4-old 1/4-new
// moving average (restarted from the new value below the reseed floor), and
// returns the averaged millivolts with a 0..100 charge percent. One item is
// in flight at a time; the 14-step microprogram runs its 7-pass restoring
// divider only when the percent is not clamped at a bound. The result sits
// in an output register, so the next item may start while it waits to be
// taken. Configuration writes apply from the next cycle and must be done
// between items.
module battery_voltage_filter #(
    parameter int SAMPLE_BITS = bvf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [SAMPLE_BITS:0]        i_sample_a,
    input  logic signed [SAMPLE_BITS:0]        i_sample_b,
    input  logic signed [SAMPLE_BITS:0]        i_sample_c,
    input  logic signed [SAMPLE_BITS:0]        i_sample_d,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [bvf_pkg::MV_W-1:0]           o_battery_mv,
    output logic [bvf_pkg::PCT_W-1:0]          o_charge_percent,
    input  logic                               i_cfg_wr_en,
    input  logic [bvf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bvf_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data
);

    localparam logic [bvf_pkg::CFG_IDX_W-1:0] CFG_CAL_GAIN   = 3'd0;
    localparam logic [bvf_pkg::CFG_IDX_W-1:0] CFG_CAL_OFFSET = 3'd1;
    localparam logic [bvf_pkg::CFG_IDX_W-1:0] CFG_RATIO      = 3'd2;
    localparam logic [bvf_pkg::CFG_IDX_W-1:0] CFG_FLOOR      = 3'd3;
    localparam logic [bvf_pkg::CFG_IDX_W-1:0] CFG_EMPTY      = 3'd4;
    localparam logic [bvf_pkg::CFG_IDX_W-1:0] CFG_FULL       = 3'd5;

    localparam bvf_pkg::t_cfg CFG_RESET = '{
        cal_gain:      16'd49611,
        cal_offset:    10'd0,
        divider_ratio: 16'd8487,
        reseed_floor:  14'd100,
        empty_mv:      14'd3300,
        full_mv:       14'd4200
    };

    bvf_pkg::t_cfg    r_cfg;
    bvf_pkg::t_op     w_op;
    bvf_pkg::t_status w_status;
    logic             w_in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            // Keep only each register's low bits; drop unknown indexes.
            unique case (i_cfg_index)
                CFG_CAL_GAIN:   r_cfg.cal_gain      <= i_cfg_wr_data;
                CFG_CAL_OFFSET: r_cfg.cal_offset    <= i_cfg_wr_data[bvf_pkg::OFFSET_W-1:0];
                CFG_RATIO:      r_cfg.divider_ratio <= i_cfg_wr_data;
                CFG_FLOOR:      r_cfg.reseed_floor  <= i_cfg_wr_data[bvf_pkg::MV_W-1:0];
                CFG_EMPTY:      r_cfg.empty_mv      <= i_cfg_wr_data[bvf_pkg::MV_W-1:0];
                CFG_FULL:       r_cfg.full_mv       <= i_cfg_wr_data[bvf_pkg::MV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = (w_op == bvf_pkg::OP_LOAD);
    assign w_in_xfer  = i_in_valid && o_in_ready;

    bvf_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    bvf_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_op),
        .i_cfg            (r_cfg),
        .i_in_valid       (i_in_valid),
        .i_in_xfer        (w_in_xfer),
        .i_sample_a       (i_sample_a),
        .i_sample_b       (i_sample_b),
        .i_sample_c       (i_sample_c),
        .i_sample_d       (i_sample_d),
        .i_out_ready      (i_out_ready),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .o_battery_mv     (o_battery_mv),
        .o_charge_percent (o_charge_percent)
    );

endmodule

// ===== hw/rtl/bvf_seq.sv =====
`include "battery_voltage_filter_assert.svh"

module bvf_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bvf_pkg::t_status i_status,
    output bvf_pkg::t_op     o_op
);

    bvf_pkg::t_pc    r_pc;
    bvf_pkg::t_pc    n_pc;
    bvf_pkg::t_uword w_uword;
    logic            w_take;

    always_comb begin
        w_uword = bvf_pkg::ucode(r_pc);
    end

    always_comb begin
        unique case (w_uword.cond)
            bvf_pkg::COND_NEXT:     w_take = 1'b0;
            bvf_pkg::COND_ALWAYS:   w_take = 1'b1;
            bvf_pkg::COND_NO_IN:    w_take = !i_status.in_valid;
            bvf_pkg::COND_OUT_BUSY: w_take = i_status.out_busy;
            bvf_pkg::COND_BOUND:    w_take = i_status.bound;
            bvf_pkg::COND_CNT_NZ:   w_take = i_status.cnt_nz;
            default:                w_take = 1'b1;
        endcase
        n_pc = w_take ? w_uword.target : r_pc + bvf_pkg::t_pc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= bvf_pkg::STEP_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op = w_uword.op;

    `BVF_ASSERT_IMPL(a_pc_in_program, i_clk, i_rst_n, 1'b1, r_pc <= bvf_pkg::STEP_OUT)
    `BVF_ASSERT_NEXT(a_out_restarts, i_clk, i_rst_n, w_uword.op == bvf_pkg::OP_OUT, r_pc == bvf_pkg::STEP_LOAD)

endmodule

// ===== hw/rtl/bvf_dp.sv =====
`include "battery_voltage_filter_assert.svh"

module bvf_dp #(
    parameter int SAMPLE_BITS = bvf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bvf_pkg::t_op                i_op,
    input  bvf_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    input  logic                        i_in_xfer,
    input  logic signed [SAMPLE_BITS:0] i_sample_a,
    input  logic signed [SAMPLE_BITS:0] i_sample_b,
    input  logic signed [SAMPLE_BITS:0] i_sample_c,
    input  logic signed [SAMPLE_BITS:0] i_sample_d,
    input  logic                        i_out_ready,
    output bvf_pkg::t_status            o_status,
    output logic                        o_out_valid,
    output logic [bvf_pkg::MV_W-1:0]    o_battery_mv,
    output logic [bvf_pkg::PCT_W-1:0]   o_charge_percent
);

    localparam int SB      = SAMPLE_BITS;
    localparam int MV_W    = bvf_pkg::MV_W;
    localparam int PCT_W   = bvf_pkg::PCT_W;
    localparam int AVG_W   = bvf_pkg::AVG_W;
    localparam int AVG_FR  = bvf_pkg::AVG_FRAC;
    localparam int PIN_W   = ((SB > bvf_pkg::OFFSET_W) ? SB : bvf_pkg::OFFSET_W) + 1;
    localparam int MUL_A_W = (PIN_W > MV_W) ? PIN_W : MV_W;
    localparam int MUL_B_W = bvf_pkg::GAIN_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SAT_LO  = bvf_pkg::RATIO_FRAC + MV_W;
    localparam int REM_W   = MV_W + PCT_W;
    localparam int DEN_W   = REM_W - 1;
    localparam int CNT_W   = bvf_pkg::CNT_W;
    localparam int EMA_W   = AVG_W + 3;

    logic [SB-1:0]      r_s [4];
    logic [SB-1:0]      n_s [4];
    logic [SB-1:0]      r_raw, n_raw;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [PIN_W-1:0]   r_pin, n_pin;
    logic [MV_W-1:0]    r_batt, n_batt;
    logic [AVG_W-1:0]   r_avg, n_avg;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [DEN_W-1:0]   r_den, n_den;
    logic [PCT_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid;
    logic [MV_W-1:0]    r_out_mv;
    logic [PCT_W-1:0]   r_out_pct;

    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_mul_p;
    logic [SB:0]        w_mid_sum;
    logic [MV_W-1:0]    w_mv;
    logic               w_reseed;
    logic [EMA_W-1:0]   w_ema_sum;
    logic               w_ge;
    logic [REM_W-1:0]   w_den_ext;
    logic [REM_W-1:0]   w_den2;
    logic               w_bound;
    logic               w_out_busy;

    function automatic logic [SB-1:0] clamp(input logic signed [SB:0] v);
        return v[SB] ? '0 : v[SB-1:0];
    endfunction

    assign w_mv      = r_avg[AVG_W-1:AVG_FR];
    assign w_mid_sum = {1'b0, r_s[1]} + {1'b0, r_s[2]};
    assign w_reseed  = (r_avg < {i_cfg.reseed_floor, {AVG_FR{1'b0}}})
                    || (r_batt < i_cfg.reseed_floor);
    assign w_ema_sum = EMA_W'(r_avg) + EMA_W'({r_avg, 1'b0})
                     + EMA_W'({r_batt, {AVG_FR{1'b0}}});
    assign w_den_ext = {1'b0, r_den};
    assign w_den2    = {r_den, 1'b0};
    assign w_ge      = (r_rem >= w_den_ext);
    assign w_bound   = (w_mv == '0) || (w_mv >= i_cfg.full_mv) || (w_mv <= i_cfg.empty_mv);
    assign w_out_busy = r_out_valid && !i_out_ready;

    // One shared multiplier for calibration, divider scaling and percent.
    always_comb begin
        unique case (i_op)
            bvf_pkg::OP_MUL_GAIN: begin
                w_mul_a = MUL_A_W'(r_raw);
                w_mul_b = i_cfg.cal_gain;
            end
            bvf_pkg::OP_MUL_RATIO: begin
                w_mul_a = MUL_A_W'(r_pin);
                w_mul_b = i_cfg.divider_ratio;
            end
            default: begin
                w_mul_a = MUL_A_W'(w_mv - i_cfg.empty_mv);
                w_mul_b = MUL_B_W'(bvf_pkg::PCT_FULL);
            end
        endcase
        w_mul_p = w_mul_a * w_mul_b;
    end

    always_comb begin
        n_s    = r_s;
        n_raw  = r_raw;
        n_prod = r_prod;
        n_pin  = r_pin;
        n_batt = r_batt;
        n_avg  = r_avg;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        unique case (i_op)
            bvf_pkg::OP_LOAD: begin
                if (i_in_xfer) begin
                    n_s[0] = clamp(i_sample_a);
                    n_s[1] = clamp(i_sample_b);
                    n_s[2] = clamp(i_sample_c);
                    n_s[3] = clamp(i_sample_d);
                end
            end
            bvf_pkg::OP_SORT_A: begin
                n_s[0] = (r_s[1] < r_s[0]) ? r_s[1] : r_s[0];
                n_s[1] = (r_s[1] < r_s[0]) ? r_s[0] : r_s[1];
                n_s[2] = (r_s[3] < r_s[2]) ? r_s[3] : r_s[2];
                n_s[3] = (r_s[3] < r_s[2]) ? r_s[2] : r_s[3];
            end
            bvf_pkg::OP_SORT_B: begin
                // Min lands in slot 0, max in slot 3; the middle pair in any order.
                n_s[0] = (r_s[2] < r_s[0]) ? r_s[2] : r_s[0];
                n_s[2] = (r_s[2] < r_s[0]) ? r_s[0] : r_s[2];
                n_s[1] = (r_s[3] < r_s[1]) ? r_s[3] : r_s[1];
                n_s[3] = (r_s[3] < r_s[1]) ? r_s[1] : r_s[3];
            end
            bvf_pkg::OP_MID: begin
                n_raw = w_mid_sum[SB:1];
            end
            bvf_pkg::OP_MUL_GAIN, bvf_pkg::OP_MUL_RATIO: begin
                n_prod = w_mul_p;
            end
            bvf_pkg::OP_OFFSET: begin
                n_pin = PIN_W'(r_prod[SB+bvf_pkg::GAIN_FRAC-1:bvf_pkg::GAIN_FRAC])
                      + PIN_W'(i_cfg.cal_offset);
            end
            bvf_pkg::OP_SAT: begin
                n_batt = (|r_prod[PROD_W-1:SAT_LO]) ? '1
                       : r_prod[SAT_LO-1:bvf_pkg::RATIO_FRAC];
            end
            bvf_pkg::OP_EMA: begin
                n_avg = w_reseed ? {r_batt, {AVG_FR{1'b0}}} : w_ema_sum[AVG_W+1:2];
            end
            bvf_pkg::OP_PCT: begin
                n_prod = w_mul_p;
                // Bounded cases skip the divider; zero reads as empty.
                n_quo  = ((w_mv != '0) && (w_mv >= i_cfg.full_mv)) ? bvf_pkg::PCT_FULL : '0;
            end
            bvf_pkg::OP_DIV_INIT: begin
                n_rem = r_prod[REM_W-1:0];
                n_den = {i_cfg.full_mv - i_cfg.empty_mv, {(PCT_W-1){1'b0}}};
                n_quo = '0;
                n_cnt = CNT_W'(PCT_W - 1);
            end
            bvf_pkg::OP_DIV_STEP: begin
                n_rem = w_ge ? r_rem - w_den_ext : r_rem;
                n_quo = {r_quo[PCT_W-2:0], w_ge};
                n_den = r_den >> 1;
                n_cnt = r_cnt - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_avg <= n_avg;
            if (i_op == bvf_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s    <= n_s;
        r_raw  <= n_raw;
        r_prod <= n_prod;
        r_pin  <= n_pin;
        r_batt <= n_batt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        if (i_op == bvf_pkg::OP_OUT) begin
            r_out_mv  <= w_mv;
            r_out_pct <= r_quo;
        end
    end

    assign o_status = '{in_valid: i_in_valid, out_busy: w_out_busy,
                        bound: w_bound, cnt_nz: (r_cnt != '0)};
    assign o_out_valid      = r_out_valid;
    assign o_battery_mv     = r_out_mv;
    assign o_charge_percent = r_out_pct;

    `BVF_ASSERT_IMPL(a_div_rem_bound, i_clk, i_rst_n, i_op == bvf_pkg::OP_DIV_STEP, r_rem < w_den2)
    `BVF_ASSERT_IMPL(a_pct_range, i_clk, i_rst_n, r_out_valid, r_out_pct <= bvf_pkg::PCT_FULL)
    `BVF_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, i_op == bvf_pkg::OP_OUT, r_out_valid)

endmodule
